### src/bbe_pkg.sv
package bbe_pkg;

   localparam int unsigned MAX_BLOCK_BYTES = 65536;
   localparam int unsigned FRACTION_BITS   = 16;
   localparam int unsigned LOG_FRAC        = 32;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned BINS            = 256;
   localparam int unsigned CNT_W           = 17;
   localparam int unsigned WLS_W           = 53;
   localparam int unsigned LOG_INT_W       = 5;
   localparam int unsigned LOG_W           = LOG_INT_W + LOG_FRAC;
   localparam int unsigned ENT_W           = 20;
   localparam int unsigned ITER_W          = 5;
   localparam int unsigned DIV_CNT_W       = 6;

   localparam logic [CNT_W-1:0] BLOCK_SIZE_RESET = CNT_W'(4096);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOG,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_UPDATE,
      ST_LOGN,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [WLS_W-1:0] weight;
   } bin_type;

endpackage

### src/bbe_ifs.sv
interface bbe_req_if;
   import bbe_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic              end_of_stream;
   modport source (output valid, output byte_value, output end_of_stream, input ready);
   modport sink (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface bbe_rsp_if;
   import bbe_pkg::*;
   logic             valid;
   logic             ready;
   logic [ENT_W-1:0] entropy_q16;
   logic [CNT_W-1:0] block_bytes;
   logic             final_block;
   modport source (output valid, output entropy_q16, output block_bytes, output final_block,
                   input ready);
   modport sink (input valid, input entropy_q16, input block_bytes, input final_block,
                 output ready);
endinterface

### src/bbe_ram.sv
module bbe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### src/block_byte_entropy.sv
// Per-block Shannon entropy of a byte stream. The 256 bin counts and their c*log2(c)
// terms sit in one 256 x 70 RAM; the valid flag of each bin is a separate register, so a
// block close clears the histogram by resetting the flags, not the RAM. Each byte goes
// through a RAM read, 32 steps of the shared squaring log2 unit, two multiply stages and
// the write-back. A closing byte then runs log2(n) on the same unit, the bit-serial
// divider and the load of the output register. The result register holds a word until
// taken; a new byte is accepted meanwhile, and only a further close waits for it.
module block_byte_entropy (
   input  logic                      clock,
   input  logic                      reset,
   bbe_req_if.sink                   req_if,
   bbe_rsp_if.source                 rsp_if,
   input  logic                      csr_write_enable,
   input  logic [bbe_pkg::CNT_W-1:0] csr_write_data
);
   import bbe_pkg::*;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        block_size_ff;
   logic [BYTE_W-1:0]       byte_ff;
   logic                    eos_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [WLS_W-1:0]        wls_ff;
   logic [BINS-1:0]         valid_ff;
   logic [CNT_W-1:0]        cnew_ff;
   logic [WLS_W-1:0]        wold_ff;
   logic [CNT_W+LOG_FRAC-1:0] prod_ff;
   logic [WLS_W-1:0]        wnew_ff;
   logic [31:0]             lg_m_ff, lg_m_in;
   logic [LOG_FRAC-1:0]     lg_frac_ff;
   logic [LOG_INT_W-1:0]    lg_int_ff;
   logic [ITER_W-1:0]       lg_cnt_ff;
   logic [CNT_W-1:0]        div_rem_ff, div_rem_in;
   logic [WLS_W-1:0]        div_sh_ff, div_sh_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;
   logic                    rsp_valid_ff;
   logic [ENT_W-1:0]        rsp_ent_ff;
   logic [CNT_W-1:0]        rsp_bytes_ff;
   logic                    rsp_final_ff;

   logic                    ram_we;
   logic [BYTE_W-1:0]       ram_addr;
   bin_type                 ram_wdata, ram_rdata, rd_bin;
   logic [CNT_W-1:0]        eff_size;
   logic                    close;
   logic                    lg_start;
   logic [CNT_W-1:0]        lg_x;
   logic [LOG_INT_W-1:0]    lg_k;
   logic [63:0]             sq;
   logic                    lg_last;
   logic                    div_last;
   logic [CNT_W:0]          trial;
   logic                    ge;
   logic [CNT_W+LOG_INT_W-1:0] hi_prod;
   logic [WLS_W-1:0]        logn, hdiff, rnd;
   logic                    emit;

   bbe_ram #(.WIDTH($bits(bin_type)), .DEPTH(BINS)) u_hist (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rd_bin   = valid_ff[byte_ff] ? ram_rdata : '0;
   assign eff_size = (block_size_ff == '0) ? CNT_W'(1) :
                     (block_size_ff > CNT_W'(MAX_BLOCK_BYTES)) ? CNT_W'(MAX_BLOCK_BYTES) :
                     block_size_ff;
   assign close    = eos_ff || (count_ff >= eff_size);
   assign lg_last  = (lg_cnt_ff == '1);
   assign div_last = (div_cnt_ff == DIV_CNT_W'(WLS_W - 1));
   assign emit     = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      lg_k = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (lg_x[i]) begin
            lg_k = LOG_INT_W'(i);
         end
      end
   end

   assign sq      = {32'b0, lg_m_ff} * {32'b0, lg_m_ff};
   assign lg_m_in = sq[63] ? sq[63:32] : sq[62:31];

   assign trial      = {div_rem_ff, div_sh_ff[WLS_W-1]};
   assign ge         = trial >= {1'b0, count_ff};
   assign div_rem_in = ge ? CNT_W'(trial - {1'b0, count_ff}) : trial[CNT_W-1:0];
   assign div_sh_in  = {div_sh_ff[WLS_W-2:0], ge};

   assign hi_prod = cnew_ff * lg_int_ff;
   assign logn    = WLS_W'({lg_int_ff, lg_frac_ff});
   assign hdiff   = (logn > div_sh_ff) ? (logn - div_sh_ff) : '0;
   assign rnd     = hdiff + (WLS_W'(1) << (LOG_FRAC - FRACTION_BITS - 1));

   assign ram_wdata.count  = cnew_ff;
   assign ram_wdata.weight = wnew_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_LOG;
         ST_LOG: begin
            if (lg_last) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_UPDATE;
         ST_UPDATE: state_in = close ? ST_LOGN : ST_IDLE;
         ST_LOGN: begin
            if (lg_last) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = byte_ff;
      lg_start     = 1'b0;
      lg_x         = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            ram_addr     = req_if.byte_value;
         end
         ST_READ: begin
            lg_start = 1'b1;
            lg_x     = CNT_W'(rd_bin.count + 1'b1);
         end
         ST_UPDATE: begin
            ram_we   = 1'b1;
            lg_start = close;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         block_size_ff <= BLOCK_SIZE_RESET;
         count_ff      <= '0;
         wls_ff        <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         lg_cnt_ff     <= '0;
         div_cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            block_size_ff <= csr_write_data;
         end
         if (state_ff == ST_EMIT && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_READ) begin
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_UPDATE) begin
            valid_ff[byte_ff] <= 1'b1;
            wls_ff            <= wls_ff + wnew_ff - wold_ff;
         end
         if (lg_start) begin
            lg_cnt_ff <= '0;
         end else if (state_ff == ST_LOG || state_ff == ST_LOGN) begin
            lg_cnt_ff <= lg_cnt_ff + 1'b1;
         end
         if (state_ff == ST_LOGN) begin
            div_cnt_ff <= '0;
         end else if (state_ff == ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         if (state_ff == ST_EMIT && emit) begin
            count_ff     <= '0;
            wls_ff       <= '0;
            valid_ff     <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_if.valid) begin
         byte_ff <= req_if.byte_value;
         eos_ff  <= req_if.end_of_stream;
      end
      if (state_ff == ST_READ) begin
         cnew_ff <= CNT_W'(rd_bin.count + 1'b1);
         wold_ff <= rd_bin.weight;
      end
      if (lg_start) begin
         lg_m_ff    <= {{(32-CNT_W){1'b0}}, lg_x} << (LOG_INT_W'(31) - lg_k);
         lg_int_ff  <= lg_k;
         lg_frac_ff <= '0;
      end else if (state_ff == ST_LOG || state_ff == ST_LOGN) begin
         lg_m_ff    <= lg_m_in;
         lg_frac_ff <= {lg_frac_ff[LOG_FRAC-2:0], sq[63]};
      end
      if (state_ff == ST_MUL_LO) begin
         prod_ff <= cnew_ff * lg_frac_ff;
      end
      if (state_ff == ST_MUL_HI) begin
         wnew_ff <= WLS_W'({hi_prod, 32'b0}) + WLS_W'(prod_ff);
      end
      if (state_ff == ST_LOGN) begin
         div_rem_ff <= '0;
         div_sh_ff  <= wls_ff;
      end else if (state_ff == ST_DIV) begin
         div_rem_ff <= div_rem_in;
         div_sh_ff  <= div_sh_in;
      end
      if (state_ff == ST_EMIT && emit) begin
         rsp_ent_ff   <= rnd[LOG_FRAC-FRACTION_BITS +: ENT_W];
         rsp_bytes_ff <= count_ff;
         rsp_final_ff <= eos_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.entropy_q16 = rsp_ent_ff;
   assign rsp_if.block_bytes = rsp_bytes_ff;
   assign rsp_if.final_block = rsp_final_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCK_BYTES))
      else $error("block byte count beyond maximum");

   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.block_bytes != '0))
      else $error("empty block reported");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit) |=> (count_ff == '0 && valid_ff == '0 && wls_ff == '0))
      else $error("histogram not cleared at block close");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == ST_READ))
      else $error("accepted word not followed by bin read");

endmodule
